### design/huffman_tree_walk_decoder_unit_defines.svh
// Assertion macros shared by the tree-walk decoder RTL.
`ifndef HUFFMAN_TREE_WALK_DECODER_UNIT_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset
`define HTW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset
`define HTW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/htw_pkg.sv
// Types and constants of the tree-walk decoder.
package htw_pkg;

    localparam int NODE_COUNT    = 512;
    localparam int IDX_W         = $clog2(NODE_COUNT);
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);
    localparam int SYM_W         = 8;
    localparam int CNT_W         = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    // Request codes
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_DECODE  = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = 2'd1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [IDX_W-1:0]   node_index;
        logic [IDX_W-1:0]   left_child;
        logic [IDX_W-1:0]   right_child;
        logic               node_is_leaf;
        logic [SYM_W-1:0]   leaf_symbol;
        logic [7:0]         data_byte;
    } in_item_t;

    typedef struct packed {
        logic [SYM_W-1:0]   symbol;
        logic               last_in_byte;
        logic               stream_done;
    } out_item_t;

    // One node table entry
    typedef struct packed {
        logic [IDX_W-1:0]   left;
        logic [IDX_W-1:0]   right;
        logic               is_leaf;
        logic [SYM_W-1:0]   symbol;
    } node_t;

endpackage

### design/huffman_tree_walk_decoder_unit.sv
// Huffman decoder: node table, tree-walk sequencer and result register.
//
// Load (type 0) and restart (type 2) requests complete in the idle state. A
// decode request (type 1) walks one bit per cycle through the node table,
// unless the result side stalls; the table's single registered read port
// sets the pace. Each decoded symbol is held in a pending register so that
// the last one of a byte can be flagged; a result can wait in the output
// register while the next request is taken. The node table is not cleared:
// load every entry the tree uses before decoding. total_symbols and
// root_index are written on the cfg port; the user must write them only
// while the block is idle, which the block itself does not enforce.
`include "huffman_tree_walk_decoder_unit_defines.svh"

module huffman_tree_walk_decoder_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  htw_pkg::in_item_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output htw_pkg::out_item_t                   m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [htw_pkg::CFG_IDX_W-1:0]        cfg_addr,
    input  logic [htw_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RD_CUR = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;

    logic [2:0]                      state_reg, state_next;
    logic [7:0]                      byte_reg, byte_next;
    logic [htw_pkg::BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [htw_pkg::IDX_W-1:0]       cur_node_reg, cur_node_next;
    logic [htw_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [htw_pkg::CNT_W-1:0]       total_reg;
    logic [htw_pkg::IDX_W-1:0]       root_reg;
    htw_pkg::node_t                  root_ent_reg, root_ent_next;
    htw_pkg::node_t                  rd_data_reg;
    logic [htw_pkg::IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [htw_pkg::SYM_W-1:0]       pend_sym_reg, pend_sym_next;
    logic                            pend_done_reg, pend_done_next;
    logic                            m_valid_reg, m_valid_next;
    htw_pkg::out_item_t              m_data_reg, m_data_next;

    htw_pkg::node_t                  node_mem [htw_pkg::NODE_COUNT];
    htw_pkg::node_t                  wr_ent;
    htw_pkg::node_t                  walk_ent;
    logic                            rd_en, wr_en;
    logic [htw_pkg::IDX_W-1:0]       rd_addr, child, walk_node;
    logic [htw_pkg::CNT_W-1:0]       cnt_inc, cnt_after;
    logic                            s_acc, out_free, hit_leaf, walk_stall, more;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Entry written by a load request
    always_comb begin
        wr_ent.left    = s_data.left_child;
        wr_ent.right   = s_data.right_child;
        wr_ent.is_leaf = s_data.node_is_leaf;
        wr_ent.symbol  = s_data.leaf_symbol;
    end

    // One walk step: resolve the node just reached, then pick the next child
    always_comb begin
        hit_leaf   = (state_reg == ST_WALK) && rd_data_reg.is_leaf;
        cnt_inc    = count_reg + 1'b1;
        cnt_after  = hit_leaf ? cnt_inc : count_reg;
        walk_ent   = hit_leaf ? root_ent_reg : rd_data_reg;
        walk_node  = hit_leaf ? root_reg : rd_idx_reg;
        walk_stall = hit_leaf && pend_valid_reg && !out_free;
        more       = (bit_cnt_reg != htw_pkg::BIT_CNT_W'(htw_pkg::BITS_PER_BYTE))
                     && (cnt_after < total_reg);
        child      = byte_reg[7] ? walk_ent.right : walk_ent.left;
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        bit_cnt_next    = bit_cnt_reg;
        cur_node_next   = cur_node_reg;
        count_next      = count_reg;
        root_ent_next   = root_ent_reg;
        rd_idx_next     = rd_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_done_next  = pend_done_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        rd_addr         = child;
        wr_en           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    case (s_data.req_type)
                        htw_pkg::REQ_LOAD: begin
                            wr_en = 1'b1;
                        end
                        htw_pkg::REQ_DECODE: begin
                            rd_en        = 1'b1;
                            rd_addr      = root_reg;
                            byte_next    = s_data.data_byte;
                            bit_cnt_next = '0;
                            state_next   = ST_RD_CUR;
                        end
                        htw_pkg::REQ_RESTART: begin
                            cur_node_next = root_reg;
                            count_next    = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD_CUR: begin
                // root entry arrives; fetch the node the walk stands on
                rd_en         = 1'b1;
                rd_addr       = cur_node_reg;
                root_ent_next = rd_data_reg;
                rd_idx_next   = cur_node_reg;
                state_next    = ST_START;
            end
            ST_START, ST_WALK: begin
                if (!walk_stall) begin
                    if (hit_leaf) begin
                        // older symbol is not the last of the byte
                        if (pend_valid_reg) begin
                            m_valid_next              = 1'b1;
                            m_data_next.symbol        = pend_sym_reg;
                            m_data_next.last_in_byte  = 1'b0;
                            m_data_next.stream_done   = pend_done_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = rd_data_reg.symbol;
                        pend_done_next  = (cnt_inc == total_reg);
                        count_next      = cnt_inc;
                    end
                    cur_node_next = walk_node;
                    if (more) begin
                        rd_en        = 1'b1;
                        rd_addr      = child;
                        rd_idx_next  = child;
                        byte_next    = {byte_reg[6:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                        state_next   = ST_WALK;
                    end else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.symbol       = pend_sym_reg;
                    m_data_next.last_in_byte = 1'b1;
                    m_data_next.stream_done  = pend_done_reg;
                    pend_valid_next          = 1'b0;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Node table, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            node_mem[s_data.node_index] <= wr_ent;
        end
        if (rd_en) begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            root_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_addr)
                htw_pkg::CFG_TOTAL: total_reg <= cfg_wdata;
                htw_pkg::CFG_ROOT:  root_reg  <= cfg_wdata[htw_pkg::IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cur_node_reg   <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_node_reg   <= cur_node_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Walk payload
    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        bit_cnt_reg  <= bit_cnt_next;
        root_ent_reg <= root_ent_next;
        rd_idx_reg   <= rd_idx_next;
        pend_sym_reg <= pend_sym_next;
        pend_done_reg <= pend_done_next;
        m_data_reg   <= m_data_next;
    end

    // Checks
    `HTW_ASSERT_IMP(a_idle_no_pending, s_ready, !pend_valid_reg,
        "pending symbol left behind when idle")
    `HTW_ASSERT_IMP(a_walk_below_total, state_reg == ST_WALK, count_reg < total_reg,
        "walking a bit after the stream finished")
    `HTW_ASSERT_IMP(a_walk_bit_range, state_reg == ST_WALK,
        (bit_cnt_reg != '0) && (bit_cnt_reg <= htw_pkg::BIT_CNT_W'(htw_pkg::BITS_PER_BYTE)),
        "bit counter out of range during walk")
    `HTW_ASSERT_NXT(a_stall_holds_read, (state_reg == ST_WALK) && walk_stall,
        $stable(rd_data_reg) && $stable(count_reg),
        "walk advanced while stalled on the result side")

endmodule
